// ===== rtl/rmd160_pkg.sv =====
// RIPEMD-160 round tables, chaining constants, shared types and round functions.
package rmd160_pkg;

  localparam int NumRounds = 80;

  typedef logic [15:0][31:0] rmd160_msg_t;     // word 0 in the lowest bits
  typedef logic [4:0][31:0]  rmd160_digest_t;  // digest word 0 in the lowest bits

  typedef struct packed {
    logic [31:0] al;
    logic [31:0] bl;
    logic [31:0] cl;
    logic [31:0] dl;
    logic [31:0] el;
    logic [31:0] ar;
    logic [31:0] br;
    logic [31:0] cr;
    logic [31:0] dr;
    logic [31:0] er;
  } rmd160_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rmd160_fifo_stat_t;

  localparam logic [31:0] IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};

  localparam logic [31:0] K_L [5] = '{
    32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E};
  localparam logic [31:0] K_R [5] = '{
    32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000};

  localparam logic [3:0] WORD_L [NumRounds] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13};

  localparam logic [3:0] WORD_R [NumRounds] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11};

  localparam logic [4:0] ROT_L [NumRounds] = '{
    5'd11, 5'd14, 5'd15, 5'd12, 5'd5, 5'd8, 5'd7, 5'd9,
    5'd11, 5'd13, 5'd14, 5'd15, 5'd6, 5'd7, 5'd9, 5'd8,
    5'd7, 5'd6, 5'd8, 5'd13, 5'd11, 5'd9, 5'd7, 5'd15,
    5'd7, 5'd12, 5'd15, 5'd9, 5'd11, 5'd7, 5'd13, 5'd12,
    5'd11, 5'd13, 5'd6, 5'd7, 5'd14, 5'd9, 5'd13, 5'd15,
    5'd14, 5'd8, 5'd13, 5'd6, 5'd5, 5'd12, 5'd7, 5'd5,
    5'd11, 5'd12, 5'd14, 5'd15, 5'd14, 5'd15, 5'd9, 5'd8,
    5'd9, 5'd14, 5'd5, 5'd6, 5'd8, 5'd6, 5'd5, 5'd12,
    5'd9, 5'd15, 5'd5, 5'd11, 5'd6, 5'd8, 5'd13, 5'd12,
    5'd5, 5'd12, 5'd13, 5'd14, 5'd11, 5'd8, 5'd5, 5'd6};

  localparam logic [4:0] ROT_R [NumRounds] = '{
    5'd8, 5'd9, 5'd9, 5'd11, 5'd13, 5'd15, 5'd15, 5'd5,
    5'd7, 5'd7, 5'd8, 5'd11, 5'd14, 5'd14, 5'd12, 5'd6,
    5'd9, 5'd13, 5'd15, 5'd7, 5'd12, 5'd8, 5'd9, 5'd11,
    5'd7, 5'd7, 5'd12, 5'd7, 5'd6, 5'd15, 5'd13, 5'd11,
    5'd9, 5'd7, 5'd15, 5'd11, 5'd8, 5'd6, 5'd6, 5'd14,
    5'd12, 5'd13, 5'd5, 5'd14, 5'd13, 5'd13, 5'd7, 5'd5,
    5'd15, 5'd5, 5'd8, 5'd11, 5'd14, 5'd14, 5'd6, 5'd14,
    5'd6, 5'd9, 5'd12, 5'd9, 5'd12, 5'd5, 5'd15, 5'd8,
    5'd8, 5'd5, 5'd12, 5'd9, 5'd12, 5'd5, 5'd14, 5'd6,
    5'd8, 5'd13, 5'd6, 5'd5, 5'd15, 5'd13, 5'd11, 5'd11};

  // Boolean function selector codes
  localparam logic [2:0] FN_XOR  = 3'd0;
  localparam logic [2:0] FN_CHX  = 3'd1;
  localparam logic [2:0] FN_ORN  = 3'd2;
  localparam logic [2:0] FN_CHZ  = 3'd3;
  localparam logic [2:0] FN_ORNZ = 3'd4;

  function automatic logic [31:0] bool_fn(input logic [2:0] sel, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    logic [31:0] f;
    case (sel)
      FN_XOR:  f = x ^ y ^ z;
      FN_CHX:  f = (x & y) | (~x & z);
      FN_ORN:  f = (x | ~y) ^ z;
      FN_CHZ:  f = (x & z) | (y & ~z);
      default: f = x ^ (y | ~z);
    endcase
    return f;
  endfunction

  // Rotate left; amount is never zero in this scheme
  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [5:0] rn;
    rn = 6'd32 - {1'b0, n};
    return (x << n) | (x >> rn);
  endfunction

endpackage

// ===== rtl/rmd160_cell.sv =====
// One RIPEMD-160 round of both lines, registered, carrying the message block along.
module rmd160_cell #(
  parameter int ROUND = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_in,
  input  rmd160_pkg::rmd160_state_t st_in,
  input  rmd160_pkg::rmd160_msg_t   msg_in,
  output logic                      valid_out,
  output rmd160_pkg::rmd160_state_t st_out,
  output rmd160_pkg::rmd160_msg_t   msg_out
);
  import rmd160_pkg::*;

  localparam int          Group = ROUND / 16;
  localparam logic [2:0]  SelL  = 3'(Group);
  localparam logic [2:0]  SelR  = 3'(4 - Group);
  localparam logic [31:0] KL    = K_L[Group];
  localparam logic [31:0] KR    = K_R[Group];
  localparam logic [3:0]  WL    = WORD_L[ROUND];
  localparam logic [3:0]  WR    = WORD_R[ROUND];
  localparam logic [4:0]  RL    = ROT_L[ROUND];
  localparam logic [4:0]  RR    = ROT_R[ROUND];

  logic          valid_r;
  rmd160_state_t st_r, st_nxt;
  rmd160_msg_t   msg_r;
  logic [31:0]   sum_l, sum_r;

  always_comb begin
    sum_l = st_in.al + bool_fn(SelL, st_in.bl, st_in.cl, st_in.dl) + msg_in[WL] + KL;
    sum_r = st_in.ar + bool_fn(SelR, st_in.br, st_in.cr, st_in.dr) + msg_in[WR] + KR;
    st_nxt.al = st_in.el;
    st_nxt.el = st_in.dl;
    st_nxt.dl = rotl(st_in.cl, 5'd10);
    st_nxt.cl = st_in.bl;
    st_nxt.bl = rotl(sum_l, RL) + st_in.el;
    st_nxt.ar = st_in.er;
    st_nxt.er = st_in.dr;
    st_nxt.dr = rotl(st_in.cr, 5'd10);
    st_nxt.cr = st_in.br;
    st_nxt.br = rotl(sum_r, RR) + st_in.er;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r  <= st_nxt;
      msg_r <= msg_in;
    end
  end

  assign valid_out = valid_r;
  assign st_out    = st_r;
  assign msg_out   = msg_r;

endmodule

// ===== rtl/rmd160_out_fifo.sv =====
// Two-entry output queue for finished digests.
module rmd160_out_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  rmd160_pkg::rmd160_digest_t     wr_data,
  input  logic                           rd_en,
  output rmd160_pkg::rmd160_digest_t     rd_data,
  output rmd160_pkg::rmd160_fifo_stat_t  stat
);
  import rmd160_pkg::*;

  rmd160_digest_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    cnt_nxt    = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.full  = cnt_r[1];
  assign stat.empty = (cnt_r == 2'd0);

endmodule

// ===== rtl/ripemd160_single_block_hash.sv =====
// Top level: RIPEMD-160 single-block compression as an 80-cell round pipeline.
//
//  channel | direction | payload                                   | handshake
//  --------+-----------+-------------------------------------------+--------------------
//  in_     | slave     | 512-bit block, bytes 0..63 from bit 0 up  | in_tvalid/in_tready
//  out_    | master    | 160-bit digest, word 0 in the lowest bits | out_tvalid/out_tready
//
// One block enters per cycle while the output queue is not full. Each of the
// 80 cells does one round of both lines and hands its state and the message
// words to the next cell at every enabled edge. A digest passes through all 80
// cells and then the output queue before it shows up on out_.
// Reset clears the valid bits of the cells and the output queue; datapath
// registers are not reset. A stalled output fills the two-entry queue; only when
// it is full does the whole chain hold and in_tready drop.
module ripemd160_single_block_hash (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [511:0] in_tdata,   // block_bytes_0_7 .. block_bytes_56_63, 64 bits each
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata   // digest_word_0 .. digest_word_4, 32 bits each
);
  import rmd160_pkg::*;

  logic              adv;  // advance the whole chain
  logic              valid_c [NumRounds+1];
  rmd160_state_t     st_c    [NumRounds+1];
  rmd160_msg_t       msg_c   [NumRounds+1];
  rmd160_state_t     st_f;
  rmd160_digest_t    digest;
  rmd160_digest_t    head;
  rmd160_fifo_stat_t fstat;
  logic              q_wr;
  logic              q_rd;

  // Hold every cell while the output queue is full
  assign adv       = !fstat.full;
  assign in_tready = adv;

  // Each transaction starts from the standard chaining value
  assign valid_c[0] = in_tvalid;
  assign msg_c[0]   = rmd160_msg_t'(in_tdata);
  assign st_c[0]    = '{al: IV[0], bl: IV[1], cl: IV[2], dl: IV[3], el: IV[4],
                        ar: IV[0], br: IV[1], cr: IV[2], dr: IV[3], er: IV[4]};

  for (genvar i = 0; i < NumRounds; i++) begin : g_cell
    rmd160_cell #(
      .ROUND(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .valid_in (valid_c[i]),
      .st_in    (st_c[i]),
      .msg_in   (msg_c[i]),
      .valid_out(valid_c[i+1]),
      .st_out   (st_c[i+1]),
      .msg_out  (msg_c[i+1])
    );
  end

  // Final cross-addition of both lines onto the chaining value
  assign st_f = st_c[NumRounds];
  always_comb begin
    digest[0] = IV[1] + st_f.cl + st_f.dr;
    digest[1] = IV[2] + st_f.dl + st_f.er;
    digest[2] = IV[3] + st_f.el + st_f.ar;
    digest[3] = IV[4] + st_f.al + st_f.br;
    digest[4] = IV[0] + st_f.bl + st_f.cr;
  end

  assign q_wr = valid_c[NumRounds] && adv;
  assign q_rd = out_tvalid && out_tready;

  rmd160_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr),
    .wr_data(digest),
    .rd_en  (q_rd),
    .rd_data(head),
    .stat   (fstat)
  );

  assign out_tvalid = !fstat.empty;
  assign out_tdata  = head;

  // Queue is never full and empty at once
  a_fifo_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(fstat.full && fstat.empty))
    else $error("output queue reports full and empty together");

  // An accepted transaction lands in the first cell
  a_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> valid_c[1])
    else $error("accepted block missing from first cell");

  // A finished digest held back by a full queue stays in the last cell
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_c[NumRounds] && !adv) |=> valid_c[NumRounds])
    else $error("finished digest dropped while queue full");

  // After a finished digest enters the queue, the output is valid in the next cycle
  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |=> out_tvalid)
    else $error("digest written to queue but output not valid");

endmodule
